// File: hw/rtl/pirs_pkg.sv
// ----------------------------------------------------------------------------
// pirs_pkg
// Shared types and codes for the positional insert/remove stack.
// ----------------------------------------------------------------------------
package pirs_pkg;

	typedef enum logic [2:0] {
		ACT_PUSH   = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_POP    = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_PEEK   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DP_HOLD = 2'd0,
		DP_INS  = 2'd1,
		DP_DEL  = 2'd2
	} dp_op_t;

	typedef enum logic [1:0] {
		IDX_POS = 2'd0,
		IDX_TOP = 2'd1,
		IDX_CNT = 2'd2
	} idx_sel_t;

	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_ONES = 2'd1,
		RES_POS  = 2'd2,
		RES_WORD = 2'd3
	} res_sel_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic     load;
		logic     exec;
		dp_op_t   op;
		idx_sel_t idx_sel;
		res_sel_t res_sel;
		status_t  status;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic pos_gt_cnt;
		logic pos_ge_cnt;
	} dp_flags_t;

	localparam int CAP_BITS   = 5;
	localparam int POS_BITS   = 5;
	localparam int VALUE_BITS = 32;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage

// File: hw/rtl/pirs_ctrl.sv
// ----------------------------------------------------------------------------
// pirs_ctrl
// Controller: accepts a transaction, decodes the action against the stack
// flags and issues one datapath command.
// ----------------------------------------------------------------------------
module pirs_ctrl
	import pirs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [2:0] action,
	input  dp_flags_t flags,
	output logic      busy,
	output dp_cmd_t   cmd
);

	state_t     state_q;
	logic [2:0] action_q;
	logic       accept;

	assign busy   = (state_q == S_EXEC);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (accept) state_q <= S_EXEC;
				S_EXEC:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.exec    = busy;
		cmd.op      = DP_HOLD;
		cmd.idx_sel = IDX_POS;
		cmd.res_sel = RES_ZERO;
		cmd.status  = ST_OK;
		case (action_q)
			ACT_PUSH: begin
				if (flags.full) begin
					cmd.status = ST_OVERFLOW;
				end else begin
					cmd.op      = DP_INS;
					cmd.idx_sel = IDX_CNT;
				end
			end
			ACT_INSERT: begin
				if (flags.full) begin
					cmd.status = ST_OVERFLOW;
				end else if (flags.pos_gt_cnt) begin
					cmd.status = ST_INVALID;
				end else begin
					cmd.op = DP_INS;
				end
			end
			ACT_POP: begin
				if (flags.empty) begin
					cmd.status  = ST_UNDERFLOW;
					cmd.res_sel = RES_ONES;
				end else begin
					cmd.op      = DP_DEL;
					cmd.idx_sel = IDX_TOP;
					cmd.res_sel = RES_WORD;
				end
			end
			ACT_REMOVE: begin
				if (flags.empty) begin
					cmd.status  = ST_UNDERFLOW;
					cmd.res_sel = RES_ONES;
				end else if (flags.pos_ge_cnt) begin
					cmd.status  = ST_INVALID;
					cmd.res_sel = RES_POS;
				end else begin
					cmd.op      = DP_DEL;
					cmd.res_sel = RES_WORD;
				end
			end
			ACT_PEEK: begin
				if (flags.empty) begin
					cmd.status  = ST_UNDERFLOW;
					cmd.res_sel = RES_ONES;
				end else begin
					cmd.idx_sel = IDX_TOP;
					cmd.res_sel = RES_WORD;
				end
			end
			default: begin
				cmd.op = DP_HOLD;
			end
		endcase
	end

endmodule

// File: hw/rtl/pirs_dp.sv
// ----------------------------------------------------------------------------
// pirs_dp
// Datapath: shifting register file, entry count, capacity register and the
// result registers.
// ----------------------------------------------------------------------------
module pirs_dp
	import pirs_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CAP_BITS-1:0]          cfg_wdata,
	input  dp_cmd_t                      cmd,
	input  logic [POS_BITS-1:0]          position,
	input  logic signed [VALUE_BITS-1:0] value,
	output dp_flags_t                    flags,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] result_value,
	output logic [1:0]                   status,
	output logic                         is_empty,
	output logic                         is_full,
	output logic [CAP_BITS-1:0]          entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

	logic [WORD_BITS-1:0]  cells_q [DEPTH];
	logic [CNT_W-1:0]      count_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [POS_BITS-1:0]   position_q;
	logic [VALUE_BITS-1:0] value_q;

	logic [CW-1:0]         cap_ext;
	logic [CW-1:0]         cap_eff;
	logic [CW-1:0]         cnt_ext;
	logic [CW-1:0]         pos_ext;
	logic [CW-1:0]         cnt_nxt;
	logic [CW-1:0]         idx;
	logic [WORD_BITS-1:0]  wr_word;
	logic [WORD_BITS-1:0]  rd_raw;
	logic [VALUE_BITS-1:0] rd_word;
	logic [VALUE_BITS-1:0] res_nxt;

	logic                         done_q;
	logic [VALUE_BITS-1:0]        result_value_q;
	status_t                      status_q;
	logic                         is_empty_q;
	logic                         is_full_q;
	logic [CAP_BITS-1:0]          entry_count_q;

	assign cap_ext = CW'(cap_q);
	assign cnt_ext = CW'(count_q);
	assign pos_ext = CW'(position_q);

	always_comb begin
		if (cap_ext == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > CW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign flags.empty      = (cnt_ext == '0);
	assign flags.full       = (cnt_ext >= cap_eff);
	assign flags.pos_gt_cnt = (pos_ext > cnt_ext);
	assign flags.pos_ge_cnt = (pos_ext >= cnt_ext);

	always_comb begin
		case (cmd.idx_sel)
			IDX_POS: idx = pos_ext;
			IDX_TOP: idx = cnt_ext - CW'(1);
			IDX_CNT: idx = cnt_ext;
			default: idx = pos_ext;
		endcase
	end

	generate
		if (WORD_BITS <= VALUE_BITS) begin : g_wr_narrow
			assign wr_word = value_q[WORD_BITS-1:0];
		end else begin : g_wr_wide
			assign wr_word = {{(WORD_BITS - VALUE_BITS){value_q[VALUE_BITS-1]}}, value_q};
		end
	endgenerate

	assign rd_raw = cells_q[idx[IW-1:0]];

	generate
		if (WORD_BITS >= VALUE_BITS) begin : g_rd_wide
			assign rd_word = rd_raw[VALUE_BITS-1:0];
		end else begin : g_rd_narrow
			assign rd_word = {{(VALUE_BITS - WORD_BITS){rd_raw[WORD_BITS-1]}}, rd_raw};
		end
	endgenerate

	always_comb begin
		case (cmd.res_sel)
			RES_ZERO: res_nxt = '0;
			RES_ONES: res_nxt = '1;
			RES_POS:  res_nxt = VALUE_BITS'(position_q);
			RES_WORD: res_nxt = rd_word;
			default:  res_nxt = '0;
		endcase
	end

	always_comb begin
		case (cmd.op)
			DP_INS:  cnt_nxt = cnt_ext + CW'(1);
			DP_DEL:  cnt_nxt = cnt_ext - CW'(1);
			default: cnt_nxt = cnt_ext;
		endcase
	end

	// Cells from the index upward shift against their fixed neighbour or take the new word
	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			always_ff @(posedge clk) begin
				if (cmd.exec) begin
					case (cmd.op)
						DP_INS: begin
							if (CW'(i) == idx) begin
								cells_q[i] <= wr_word;
							end else if (CW'(i) > idx) begin
								cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
							end
						end
						DP_DEL: begin
							if ((CW'(i) >= idx) && (i < DEPTH - 1)) begin
								cells_q[i] <= cells_q[(i < DEPTH - 1) ? i + 1 : i];
							end
						end
						default: begin
							cells_q[i] <= cells_q[i];
						end
					endcase
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				count_q <= cnt_nxt[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			position_q <= position;
			value_q    <= value;
		end
		if (cmd.exec) begin
			result_value_q <= res_nxt;
			status_q       <= cmd.status;
			is_empty_q     <= (cnt_nxt == '0);
			is_full_q      <= (cnt_nxt >= cap_eff);
			entry_count_q  <= CAP_BITS'(cnt_nxt);
		end
	end

	assign done         = done_q;
	assign result_value = result_value_q;
	assign status       = status_q;
	assign is_empty     = is_empty_q;
	assign is_full      = is_full_q;
	assign entry_count  = entry_count_q;

endmodule

// File: hw/rtl/positional_insert_remove_stack_top.sv
// ----------------------------------------------------------------------------
// positional_insert_remove_stack_top
// Bounded stack of signed words with push, pop, peek and insert or remove at
// a position counted from the bottom.
// ----------------------------------------------------------------------------
//  Channel   | Handshake              | Payload
//  ----------+------------------------+----------------------------------------
//  command   | start / busy           | action, position, value
//  result    | done (one-cycle strobe)| result_value, status, is_empty,
//            |                        | is_full, entry_count
//  config    | cfg_we                 | cfg_wdata (capacity)
//
//  Each transaction is accepted in the idle state, then executed in the
//  controller's execute state, during which busy is high. The result appears
//  with done in the cycle after execution. The cells shift together during
//  execution, so the cost does not depend on position or depth.
//  Reset clears the count and sets capacity to 16; no clearing pass.
//  The receiver cannot stall; a new transaction may start while done is high.
// ----------------------------------------------------------------------------
module positional_insert_remove_stack_top
	import pirs_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   action,
	input  logic [POS_BITS-1:0]          position,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         cfg_we,
	input  logic [CAP_BITS-1:0]          cfg_wdata,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] result_value,
	output logic [1:0]                   status,
	output logic                         is_empty,
	output logic                         is_full,
	output logic [CAP_BITS-1:0]          entry_count
);

	dp_cmd_t   cmd;
	dp_flags_t flags;

	pirs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.flags  (flags),
		.busy   (busy),
		.cmd    (cmd)
	);

	pirs_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.position     (position),
		.value        (value),
		.flags        (flags),
		.done         (done),
		.result_value (result_value),
		.status       (status),
		.is_empty     (is_empty),
		.is_full      (is_full),
		.entry_count  (entry_count)
	);

`ifndef SYNTHESIS
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted transaction gave no result");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without execution");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_underflow_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_UNDERFLOW)) |-> (result_value == '1))
		else $error("underflow without all-ones value");
`endif

endmodule
